@@ src/udpck_pkg.sv @@
// constants and types shared by the udp/ipv4 checksum generator
package udpck_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned SUM_W   = 20;

    localparam int unsigned S_DATA_W = 120;
    localparam int unsigned M_DATA_W = 64;

    localparam logic [BYTE_W-1:0]  TTL_RESET     = 8'd64;
    localparam logic [WORD_W-1:0]  IP_VER_IHL    = 16'h4500;
    localparam logic [WORD_W-1:0]  IP_FLAGS_DF   = 16'h4000;
    localparam logic [BYTE_W-1:0]  PROTO_UDP     = 8'd17;
    localparam logic [WORD_W-1:0]  LEN_SAT       = 16'hFFFF;
    localparam logic [WORD_W-1:0]  IP_HDR_BYTES  = 16'd20;
    localparam logic [WORD_W-1:0]  IP_UDP_BYTES  = 16'd28;
    localparam logic [WORD_W-1:0]  UDP_HDR_BYTES = 16'd8;
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD   = 17'd65507;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 17'h1FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] ident;
        logic [WORD_W-1:0] dest_port;
        logic [WORD_W-1:0] source_port;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] source_addr;
        logic [BYTE_W-1:0] payload_byte;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] udp_checksum;
        logic [WORD_W-1:0] datagram_length;
        logic [WORD_W-1:0] header_checksum;
        logic [WORD_W-1:0] total_length;
    } out_word_t;

    // two end-around folds bring a 20-bit sum back to 16 bits
    function automatic logic [WORD_W-1:0] fold_sum(input logic [SUM_W-1:0] s);
        logic [WORD_W:0] s1;
        logic [WORD_W:0] s2;
        s1 = {1'b0, s[WORD_W-1:0]} + (WORD_W+1)'(s[SUM_W-1:WORD_W]);
        s2 = {1'b0, s1[WORD_W-1:0]} + (WORD_W+1)'(s1[WORD_W]);
        return s2[WORD_W-1:0];
    endfunction

endpackage

@@ src/udp_ipv4_header_checksum_gen_top.sv @@
// udp/ipv4 length and checksum generator, top level
// a closing word passes through the input register, then its result is held in the output register on m_axis
// one input word per cycle unless a closing word waits; the running sum is one add and fold per word
// words without tlast keep moving past a waiting result; a closing word waits for it to go
// reset (rst_n low, asynchronous): running sum, byte count and pending byte cleared,
// both stages empty, time_to_live back to 64
module udp_ipv4_header_checksum_gen_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // payload_byte, source_addr, dest_addr, source_port, dest_port, ident
    input  logic [udpck_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // has_byte
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // total_length, header_checksum, datagram_length, udp_checksum
    output logic [udpck_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // too_long
    output logic                               m_axis_tuser,
    input  logic                               cfg_we,
    input  logic [udpck_pkg::BYTE_W-1:0]       cfg_wdata
);
    import udpck_pkg::*;

    logic                in_valid_reg;
    in_word_t            in_word_reg;
    logic                in_has_reg;
    logic                in_last_reg;

    logic [BYTE_W-1:0]   ttl_reg;
    logic [WORD_W-1:0]   running_sum_reg;
    logic [WORD_W-1:0]   running_sum_next;
    logic [COUNT_W-1:0]  byte_count_reg;
    logic [COUNT_W-1:0]  byte_count_next;
    logic [BYTE_W-1:0]   pending_high_reg;
    logic [BYTE_W-1:0]   pending_high_next;
    logic                odd_pending_reg;
    logic                odd_pending_next;

    logic                out_valid_reg;
    out_word_t           out_word_reg;
    out_word_t           out_word_next;
    logic                too_long_reg;
    logic                too_long_next;

    logic                consume;
    logic [WORD_W:0]     pair_sum;
    logic [SUM_W-1:0]    ip_sum;
    logic [SUM_W-1:0]    udp_sum;
    logic [WORD_W-1:0]   tot_len;
    logic [WORD_W-1:0]   udp_len;
    logic [WORD_W-1:0]   pend_word;

    assign consume       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg <= in_word_t'(s_axis_tdata);
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TTL_RESET;
        end
        else if (cfg_we)
        begin
            ttl_reg <= cfg_wdata;
        end
    end

    // per-byte state update, including the byte carried by a last word
    always_comb
    begin
        running_sum_next  = running_sum_reg;
        byte_count_next   = byte_count_reg;
        pending_high_next = pending_high_reg;
        odd_pending_next  = odd_pending_reg;
        pair_sum = {1'b0, running_sum_reg} + {1'b0, pending_high_reg, in_word_reg.payload_byte};
        if (in_has_reg)
        begin
            if (odd_pending_reg)
            begin
                running_sum_next  = pair_sum[WORD_W-1:0] + WORD_W'(pair_sum[WORD_W]);
                pending_high_next = '0;
                odd_pending_next  = 1'b0;
            end
            else
            begin
                pending_high_next = in_word_reg.payload_byte;
                odd_pending_next  = 1'b1;
            end
            if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    // closing sums for the last word of a datagram
    always_comb
    begin
        too_long_next = byte_count_next > MAX_PAYLOAD;
        if (too_long_next)
        begin
            tot_len = LEN_SAT;
            udp_len = LEN_SAT - IP_HDR_BYTES;
        end
        else
        begin
            tot_len = WORD_W'(byte_count_next) + IP_UDP_BYTES;
            udp_len = WORD_W'(byte_count_next) + UDP_HDR_BYTES;
        end
        pend_word = odd_pending_next ? {pending_high_next, 8'h00} : '0;

        ip_sum = SUM_W'(IP_VER_IHL) + SUM_W'(tot_len) + SUM_W'(in_word_reg.ident)
               + SUM_W'(IP_FLAGS_DF) + SUM_W'({ttl_reg, PROTO_UDP})
               + SUM_W'(in_word_reg.source_addr[ADDR_W-1:WORD_W])
               + SUM_W'(in_word_reg.source_addr[WORD_W-1:0])
               + SUM_W'(in_word_reg.dest_addr[ADDR_W-1:WORD_W])
               + SUM_W'(in_word_reg.dest_addr[WORD_W-1:0]);

        udp_sum = SUM_W'(in_word_reg.source_addr[ADDR_W-1:WORD_W])
                + SUM_W'(in_word_reg.source_addr[WORD_W-1:0])
                + SUM_W'(in_word_reg.dest_addr[ADDR_W-1:WORD_W])
                + SUM_W'(in_word_reg.dest_addr[WORD_W-1:0])
                + SUM_W'(PROTO_UDP) + SUM_W'(udp_len) + SUM_W'(udp_len)
                + SUM_W'(in_word_reg.source_port) + SUM_W'(in_word_reg.dest_port)
                + SUM_W'(running_sum_next) + SUM_W'(pend_word);

        out_word_next.total_length    = tot_len;
        out_word_next.header_checksum = ~fold_sum(ip_sum);
        out_word_next.datagram_length = udp_len;
        out_word_next.udp_checksum    = ~fold_sum(udp_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg  <= '0;
            byte_count_reg   <= '0;
            pending_high_reg <= '0;
            odd_pending_reg  <= 1'b0;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                running_sum_reg  <= '0;
                byte_count_reg   <= '0;
                pending_high_reg <= '0;
                odd_pending_reg  <= 1'b0;
            end
            else
            begin
                running_sum_reg  <= running_sum_next;
                byte_count_reg   <= byte_count_next;
                pending_high_reg <= pending_high_next;
                odd_pending_reg  <= odd_pending_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_word_reg <= out_word_next;
            too_long_reg <= too_long_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(out_word_reg);
    assign m_axis_tuser  = too_long_reg;

    // odd byte flag tracks the count parity until the count saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg != COUNT_MAX) |-> (odd_pending_reg == byte_count_reg[0]))
        else $error("odd byte flag out of step with byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !odd_pending_reg |-> (pending_high_reg == '0))
        else $error("pending byte not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (byte_count_reg == '0 && running_sum_reg == '0))
        else $error("datagram state not cleared after last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[WORD_W-1:0] == LEN_SAT))
        else $error("oversized datagram without saturated length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !(consume && in_last_reg)) |=> !m_axis_tvalid)
        else $error("result repeated after it was taken");

endmodule
